// ===== sv/rnmc_pkg.sv =====
package rnmc_pkg;

  // Sizes of the raster
  localparam int MaxWidth   = 128;
  localparam int MaxHeight  = 4096;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxHeight + 2);
  localparam int WidthRegW  = 8;
  localparam int HeightRegW = 13;
  localparam int CfgDataW   = 13;
  localparam int CountW     = 4;
  localparam int WinW       = 9;

  // Register indexes of the configuration port
  localparam logic RegFrameWidth  = 1'b0;
  localparam logic RegFrameHeight = 1'b1;

  // Kind of an input request
  localparam logic FuncCell  = 1'b0;
  localparam logic FuncDrain = 1'b1;

  // One column of the two line stores
  typedef struct packed {
    logic mid;
    logic up;
  } rnmc_pair_t;

  // Position masks for the neighbour count
  typedef struct packed {
    logic col_zero;
    logic left_ok;
    logic top_ok;
    logic bottom_ok;
  } rnmc_win_ctrl_t;

  typedef struct packed {
    logic              end_of_frame;
    logic              end_of_row;
    logic [CountW-1:0] neighbor_count;
    logic              is_marked;
  } rnmc_result_t;

endpackage

// ===== sv/rnmc_cell.sv =====
module rnmc_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  logic               load_i,
  input  rnmc_pkg::rnmc_pair_t ins_i,
  input  rnmc_pkg::rnmc_pair_t nxt_i,
  output rnmc_pkg::rnmc_pair_t q_o
);

  rnmc_pkg::rnmc_pair_t pair_q, pair_d;

  // the insertion cell takes the new column, the others take their neighbour
  assign pair_d = load_i ? ins_i : nxt_i;
  assign q_o    = pair_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q <= '0;
    end else if (shift_i) begin
      pair_q <= pair_d;
    end
  end

endmodule

// ===== sv/rnmc_window.sv =====
module rnmc_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic                          clear_i,
  input  logic [2:0]                    col_i,   // bit 0 upper, bit 1 middle, bit 2 new
  input  rnmc_pkg::rnmc_win_ctrl_t      ctrl_i,
  output logic                          marked_o,
  output logic [rnmc_pkg::CountW-1:0]   count_o
);

  logic [rnmc_pkg::WinW-1:0] win_q, win_d, win_next;

  assign win_next = {col_i, win_q[rnmc_pkg::WinW-1:3]};

  always_comb begin
    win_d = win_q;
    if (shift_i) begin
      win_d = win_next;
    end
    if (clear_i) begin
      win_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  // End of row: centre is the newest column of the old window.
  // Otherwise centre is the middle column of the shifted-in window.
  always_comb begin
    logic [rnmc_pkg::WinW-1:0] use_w;
    logic [2:0]                lc;
    logic [2:0]                cc;
    logic [2:0]                rc;
    logic                      t;
    logic                      b;
    logic                      lok;
    logic                      rok;
    logic [7:0]                nb;
    use_w = ctrl_i.col_zero ? win_q : win_next;
    lc    = ctrl_i.col_zero ? use_w[5:3] : use_w[2:0];
    cc    = ctrl_i.col_zero ? use_w[8:6] : use_w[5:3];
    rc    = use_w[8:6];
    t     = ctrl_i.top_ok;
    b     = ctrl_i.bottom_ok;
    lok   = ctrl_i.left_ok;
    rok   = !ctrl_i.col_zero;
    nb    = {lc[0] & t & lok, lc[1] & lok, lc[2] & b & lok,
             cc[0] & t, cc[2] & b,
             rc[0] & t & rok, rc[1] & rok, rc[2] & b & rok};
    marked_o = cc[1];
    count_o  = cc[1] ? '0 : rnmc_pkg::CountW'($countones(nb));
  end

endmodule

// ===== sv/raster_neighbor_mark_count.sv =====
// Streaming 3x3 neighbour counter for a binary raster. Cells come in row-major
// order, one request per cycle, and each gives one result: the marked flag of
// the cell, or if it is empty the number (0..8) of marked cells around it, with
// cells outside the frame taken as empty. A result leaves frame_width+1 requests
// after its own cell, so frame_width+1 drain requests (tuser high) follow the
// last cell to flush the frame; surplus cells act as drains. The block takes one
// request every cycle with no bubbles; the only limit is the downstream ready,
// since a result register plus a skid register decouple the two sides. The two
// line stores are a chain of 128 two-bit cells that shift on every request; new
// data enters at cell frame_width-1 and leaves at cell 0, so the chain acts as a
// delay of exactly one row. No clearing pass is needed: stale line bits only
// ever fall outside the frame and are masked. Writing either register restarts
// the frame; write only while the block is idle.
module raster_neighbor_mark_count (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [0] cell_marked
  input  logic                            s_axis_tuser,  // [0] func
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // [0] is_marked, [4:1] neighbor_count
  output logic                            m_axis_tlast,  // end_of_frame
  output logic                            m_axis_tuser,  // [0] end_of_row
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [rnmc_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int ColW = rnmc_pkg::ColW;
  localparam int RowW = rnmc_pkg::RowW;
  localparam int WW   = rnmc_pkg::WidthRegW;
  localparam int HW   = rnmc_pkg::HeightRegW;
  localparam int MaxW = rnmc_pkg::MaxWidth;

  // ---------------- configuration ----------------
  logic [WW-1:0] width_q;
  logic [HW-1:0] height_q;
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;

  // zero acts as one, anything above the maximum as the maximum
  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (width_q > WW'(MaxW)) begin
      eff_w = WW'(MaxW);
    end else begin
      eff_w = width_q;
    end
    if (height_q == '0) begin
      eff_h = HW'(1);
    end else if (height_q > HW'(rnmc_pkg::MaxHeight)) begin
      eff_h = HW'(rnmc_pkg::MaxHeight);
    end else begin
      eff_h = height_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(MaxW);
      height_q <= HW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rnmc_pkg::RegFrameWidth:  width_q  <= cfg_data_i[WW-1:0];
        rnmc_pkg::RegFrameHeight: height_q <= cfg_data_i[HW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- input side and position ----------------
  logic            in_fire;
  logic            cell_v;
  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic            col_zero;
  logic [RowW:0]   cp2;      // centre row plus two
  logic [RowW:0]   h_plus1;
  logic            emit;
  logic            last_row;
  logic            frame_end;
  logic [WW-1:0]   col_inc;
  logic            wrap;
  rnmc_pkg::rnmc_win_ctrl_t win_ctrl;

  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign cell_v   = (s_axis_tuser == rnmc_pkg::FuncCell) & s_axis_tdata[0];
  assign col_zero = (col_q == '0);

  // at column zero the result is for the end of the row before last
  assign cp2      = col_zero ? {1'b0, row_q} : {1'b0, row_q} + 1'b1;
  assign h_plus1  = (RowW+1)'(eff_h) + 1'b1;
  assign emit     = (cp2 >= (RowW+1)'(2)) && (cp2 <= h_plus1);
  assign last_row = (cp2 == h_plus1);
  assign frame_end = emit & col_zero & last_row;

  assign win_ctrl.col_zero  = col_zero;
  assign win_ctrl.left_ok   = col_zero ? (eff_w >= WW'(2)) : (col_q >= ColW'(2));
  assign win_ctrl.top_ok    = (cp2 >= (RowW+1)'(3));
  assign win_ctrl.bottom_ok = (cp2 < h_plus1);

  assign col_inc = {1'b0, col_q} + 1'b1;
  assign wrap    = (col_inc >= eff_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_we_i) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      if (frame_end) begin
        col_q <= '0;
        row_q <= '0;
      end else if (wrap) begin
        col_q <= '0;
        row_q <= row_q + 1'b1;
      end else begin
        col_q <= col_inc[ColW-1:0];
      end
    end
  end

  // ---------------- line store chain ----------------
  rnmc_pkg::rnmc_pair_t chain_q [MaxW];
  rnmc_pkg::rnmc_pair_t ins_pair;
  logic [ColW-1:0]      tap;

  assign tap          = ColW'(eff_w - 1'b1);
  assign ins_pair.mid = cell_v;
  assign ins_pair.up  = chain_q[0].mid;

  for (genvar k = 0; k < MaxW; k++) begin : g_cell
    rnmc_pkg::rnmc_pair_t nxt;
    if (k == MaxW - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_body
      assign nxt = chain_q[k+1];
    end
    rnmc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_fire),
      .load_i  (tap == ColW'(k)),
      .ins_i   (ins_pair),
      .nxt_i   (nxt),
      .q_o     (chain_q[k])
    );
  end

  // ---------------- 3x3 window and count ----------------
  logic                        marked;
  logic [rnmc_pkg::CountW-1:0] count;

  rnmc_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (in_fire),
    .clear_i  (cfg_we_i | (in_fire & frame_end)),
    .col_i    ({cell_v, chain_q[0].mid, chain_q[0].up}),
    .ctrl_i   (win_ctrl),
    .marked_o (marked),
    .count_o  (count)
  );

  // ---------------- result register and skid ----------------
  rnmc_pkg::rnmc_result_t new_res;
  rnmc_pkg::rnmc_result_t out_q, out_d, skid_q, skid_d;
  logic out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic out_fire, have_new;

  assign new_res.is_marked      = marked;
  assign new_res.neighbor_count = count;
  assign new_res.end_of_row     = col_zero;
  assign new_res.end_of_frame   = frame_end;

  assign out_fire = out_v_q & m_axis_tready;
  assign have_new = in_fire & emit;

  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (skid_v_q) begin
      if (out_fire) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (out_v_q && !out_fire) begin
      if (have_new) begin
        skid_d   = new_res;
        skid_v_d = 1'b1;
      end
    end else if (have_new) begin
      out_d   = new_res;
      out_v_d = 1'b1;
    end else if (out_fire) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign s_axis_tready = !skid_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {3'b000, out_q.neighbor_count, out_q.is_marked};
  assign m_axis_tlast  = out_q.end_of_frame;
  assign m_axis_tuser  = out_q.end_of_row;

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a result while the output register is empty");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.neighbor_count <= 4'd8))
    else $error("neighbour count above eight");

  a_marked_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.is_marked) |-> (out_q.neighbor_count == '0))
    else $error("marked cell with a non-zero count");

  a_frame_end_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.end_of_frame) |-> out_q.end_of_row)
    else $error("frame end not on a row end");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |-> ({1'b0, col_q} < eff_w))
    else $error("column beyond frame width");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && frame_end && !cfg_we_i) |=> (col_q == '0 && row_q == '0))
    else $error("position not cleared after frame end");

endmodule

// ===== dv/rnmc_checker.sv =====
`timescale 1ns / 100ps

module rnmc_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [0] cell_marked
  input  logic                          s_axis_tuser,   // [0] func
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [7:0]                    m_axis_tdata,   // [0] is_marked, [4:1] neighbor_count
  input  logic                          m_axis_tlast,   // end_of_frame
  input  logic                          m_axis_tuser,   // [0] end_of_row
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [rnmc_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  logic [rnmc_pkg::WidthRegW-1:0]  width_reg;
  logic [rnmc_pkg::HeightRegW-1:0] height_reg;
  logic                            upper_line  [rnmc_pkg::MaxWidth];
  logic                            middle_line [rnmc_pkg::MaxWidth];
  logic [rnmc_pkg::WinW-1:0]       window;
  int unsigned                     next_col;
  int unsigned                     next_row;
  int                              mismatches = 0;
  int                              results_seen = 0;
  rnmc_pkg::rnmc_result_t          cell_results_q[$];

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    // keep the log short on a badly broken build, but count everything
    if (mismatches < 30) $display("%0t ns  result %0d: %s", $time, results_seen, msg);
    mismatches++;
  endtask

  task automatic restart_frame();
    window   = '0;
    next_col = 0;
    next_row = 0;
  endtask

  task automatic write_register(input logic idx,
                                input logic [rnmc_pkg::CfgDataW-1:0] value);
    if (idx == rnmc_pkg::RegFrameWidth) width_reg = value[rnmc_pkg::WidthRegW-1:0];
    else                                height_reg = value[rnmc_pkg::HeightRegW-1:0];
    restart_frame();
  endtask

  // One request into the window model; pushes the result it gives, if any.
  task automatic predict_request(input logic func, input logic mark);
    int unsigned            w, h, c, r, cc, crow_p2, crow, col, nb;
    logic                   v, up, mid, left_ok, eor, last_row;
    logic [8:0]             pre, sel;
    rnmc_pkg::rnmc_result_t res;
    w = (width_reg == 0) ? 1 :
        ((width_reg > rnmc_pkg::MaxWidth) ? rnmc_pkg::MaxWidth : width_reg);
    h = (height_reg == 0) ? 1 :
        ((height_reg > rnmc_pkg::MaxHeight) ? rnmc_pkg::MaxHeight : height_reg);
    c = next_col;
    r = next_row;
    v = (func == rnmc_pkg::FuncCell) ? mark : 1'b0;
    pre = window;
    up  = upper_line[c];
    mid = middle_line[c];
    upper_line[c]  = mid;
    middle_line[c] = v;
    window = {v, mid, up, pre[8:3]};

    // column 0 closes the previous row: centre sits in the newest window column
    if (c == 0) begin
      cc = 2; left_ok = (w >= 2); crow_p2 = r; eor = 1'b1; sel = pre;
    end else begin
      cc = 1; left_ok = (c >= 2); crow_p2 = r + 1; eor = 1'b0; sel = window;
    end

    if (crow_p2 >= 2 && crow_p2 - 2 < h) begin
      crow = crow_p2 - 2;
      nb = 0;
      for (int dc = 0; dc < 3; dc++) begin
        col = cc + dc - 1;
        if (dc == 0 && !left_ok) continue;
        if (dc == 2 && (c == 0 || col > 2)) continue;
        for (int rw = 0; rw < 3; rw++) begin
          if (dc == 1 && rw == 1) continue;
          if (rw == 0 && crow == 0) continue;
          if (rw == 2 && crow + 1 >= h) continue;
          nb += sel[col*3 + rw];
        end
      end
      last_row = (crow + 1 == h);
      res.is_marked      = sel[cc*3 + 1];
      res.neighbor_count = res.is_marked ? '0 : nb[rnmc_pkg::CountW-1:0];
      res.end_of_row     = eor;
      res.end_of_frame   = eor && last_row;
      cell_results_q.push_back(res);
      if (res.end_of_frame) begin
        restart_frame();
        return;
      end
    end

    if (c + 1 >= w) begin
      next_col = 0;
      next_row = r + 1;
    end else begin
      next_col = c + 1;
    end
  endtask

  task automatic check_result();
    rnmc_pkg::rnmc_result_t want;
    if (cell_results_q.size() == 0) begin
      report_mismatch($sformatf("result with none expected, tdata=%h", m_axis_tdata));
    end else begin
      want = cell_results_q.pop_front();
      if (m_axis_tdata[0] !== want.is_marked)
        report_mismatch($sformatf("is_marked %b, want %b", m_axis_tdata[0], want.is_marked));
      if (m_axis_tdata[4:1] !== want.neighbor_count)
        report_mismatch($sformatf("neighbor_count %0d, want %0d",
                                  m_axis_tdata[4:1], want.neighbor_count));
      if (m_axis_tuser !== want.end_of_row)
        report_mismatch($sformatf("end_of_row %b, want %b", m_axis_tuser, want.end_of_row));
      if (m_axis_tlast !== want.end_of_frame)
        report_mismatch($sformatf("end_of_frame %b, want %b",
                                  m_axis_tlast, want.end_of_frame));
    end
    results_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = rnmc_pkg::WidthRegW'(rnmc_pkg::MaxWidth);
      height_reg = rnmc_pkg::HeightRegW'(1);
      for (int i = 0; i < rnmc_pkg::MaxWidth; i++) begin
        upper_line[i]  = 1'b0;
        middle_line[i] = 1'b0;
      end
      restart_frame();
      cell_results_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) predict_request(s_axis_tuser, s_axis_tdata[0]);
      if (cfg_we_i) write_register(cfg_idx_i, cfg_data_i);
    end
    pending_o = cell_results_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the raster neighbour counter. The checker beside
// the block does all prediction and comparison; this module only feeds
// frames, stalls the result side and waits for the checker to drain.
module testbench;

  typedef enum logic [1:0] {
    RxFree,   // ready every cycle
    RxCoin,   // ready half the time
    RxSlow,   // ready one cycle in four on average
    RxBeat    // three ready, one stall, repeating
  } rx_mode_e;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata;   // [0] cell_marked
  logic                          s_axis_tuser;   // [0] func
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [7:0]                    m_axis_tdata;   // [0] is_marked, [4:1] neighbor_count
  logic                          m_axis_tlast;   // end_of_frame
  logic                          m_axis_tuser;   // [0] end_of_row
  logic                          cfg_we_i;
  logic                          cfg_idx_i;
  logic [rnmc_pkg::CfgDataW-1:0] cfg_data_i;

  int       fail_count;
  int       pending;
  int       burst_left = 0;
  int       requests_sent = 0;
  rx_mode_e rx_mode;

  raster_neighbor_mark_count dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  rnmc_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 12 ns period
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop. A correct run needs well under a tenth of this.
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: each mode holds for a random stretch of cycles, so stalls
  // land on every phase of the frame, with stretches of no stall at all.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      for (int k = $urandom_range(20, 300); k > 0; k--) begin
        @(negedge clk_i);
        case (rx_mode)
          RxFree: begin
            m_axis_tready = 1'b1;
          end
          RxCoin: begin
            m_axis_tready = 1'($urandom_range(0, 1));
          end
          RxSlow: begin
            m_axis_tready = ($urandom_range(0, 3) == 0);
          end
          default: begin
            m_axis_tready = (k % 4 != 0);
          end
        endcase
      end
    end
  end

  // Same clamp the block applies to out-of-range register values.
  function automatic int unsigned clamp_dim(input int unsigned raw, input int unsigned top);
    return (raw == 0) ? 1 : ((raw > top) ? top : raw);
  endfunction

  // Called at a falling edge; the write lands on the next rising edge.
  task automatic write_reg(input logic idx, input int unsigned value);
    cfg_idx_i  = idx;
    cfg_data_i = value[rnmc_pkg::CfgDataW-1:0];
    cfg_we_i   = 1'b1;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  // One input request. Requests go out in bursts; between bursts tvalid
  // drops for a random gap (sometimes none, so bursts run together).
  task automatic send_req(input logic func, input logic mark);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = func;
    s_axis_tdata  = {7'b0, mark};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    burst_left--;
    requests_sent++;
  endtask

  // Hold the sender off until every predicted result has come back, then let
  // the clock run on with tvalid low: a trailing drain that gives no result
  // is never held in the result/skid registers.
  task automatic quiesce();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // One phase: fresh register values, then one to three frames back to back.
  // The last frame is sometimes cut short; the next register write restarts.
  task automatic run_phase();
    int unsigned wr, hr, w, h, frames, density, total;
    logic        cut;
    wr     = $urandom_range(1, 8);
    hr     = $urandom_range(1, 6);
    frames = $urandom_range(1, 3);
    cut    = 1'b0;
    case ($urandom_range(0, 19))
      0: begin   // register above the limit, acts as the widest frame
        wr = 255; hr = $urandom_range(1, 2); frames = 1;
      end
      1: begin
        wr = $urandom_range(rnmc_pkg::MaxWidth, 254); hr = $urandom_range(1, 2); frames = 1;
      end
      2: begin   // tallest setting, only a slice of it is sent
        wr = $urandom_range(1, 3); hr = $urandom_range(0, 1) ? 8191 : rnmc_pkg::MaxHeight;
        frames = 1; cut = 1'b1;
      end
      3: begin   // single column, zero acting as one
        wr = $urandom_range(0, 1); hr = $urandom_range(20, 40);
      end
      4: begin
        wr = $urandom_range(9, 40); hr = $urandom_range(0, 3);
      end
      default: begin
      end
    endcase
    write_reg(rnmc_pkg::RegFrameWidth, wr);
    write_reg(rnmc_pkg::RegFrameHeight, hr);
    w = clamp_dim(wr, rnmc_pkg::MaxWidth);
    h = clamp_dim(hr, rnmc_pkg::MaxHeight);

    case ($urandom_range(0, 4))
      0:       density = 0;
      1:       density = 100;
      default: density = $urandom_range(10, 90);
    endcase

    for (int f = 0; f < frames; f++) begin
      total = w * h;
      if (f == frames - 1 && $urandom_range(0, 7) == 0) cut = 1'b1;
      if (cut) total = $urandom_range(1, (total > 60) ? 60 : total);
      for (int i = 0; i < total; i++) begin
        // now and then a drain in mid-frame, standing in for an empty cell
        if ($urandom_range(0, 31) == 0) begin
          send_req(rnmc_pkg::FuncDrain, 1'($urandom_range(0, 1)));
        end else begin
          send_req(rnmc_pkg::FuncCell, $urandom_range(0, 99) < density);
        end
      end
      // flush: width+1 drains, some replaced by surplus cells
      if (!cut) begin
        for (int i = 0; i <= w; i++) begin
          if ($urandom_range(0, 3) == 0) send_req(rnmc_pkg::FuncCell, 1'($urandom_range(0, 1)));
          else send_req(rnmc_pkg::FuncDrain, 1'($urandom_range(0, 1)));
        end
      end
    end
    quiesce();
  endtask

  initial begin
    logic [8:0] ring;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = rnmc_pkg::FuncCell;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = rnmc_pkg::RegFrameWidth;
    cfg_data_i    = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // 3x3: empty centre ringed by marks gives the full count of eight,
    // corners and edges see the frame border
    ring = 9'b111_101_111;
    write_reg(rnmc_pkg::RegFrameWidth, 3);
    write_reg(rnmc_pkg::RegFrameHeight, 3);
    for (int i = 0; i < 9; i++) send_req(rnmc_pkg::FuncCell, ring[i]);
    repeat (4) send_req(rnmc_pkg::FuncDrain, 1'b1);   // mark bit must be ignored
    quiesce();

    // zero in both registers acts as 1x1; a surplus cell flushes like a drain
    write_reg(rnmc_pkg::RegFrameWidth, 0);
    write_reg(rnmc_pkg::RegFrameHeight, 0);
    send_req(rnmc_pkg::FuncCell, 1'b1);
    send_req(rnmc_pkg::FuncCell, 1'b1);
    send_req(rnmc_pkg::FuncDrain, 1'b0);
    quiesce();

    // 2x2 with an early drain in place of the second cell
    write_reg(rnmc_pkg::RegFrameWidth, 2);
    write_reg(rnmc_pkg::RegFrameHeight, 2);
    send_req(rnmc_pkg::FuncCell, 1'b0);
    send_req(rnmc_pkg::FuncDrain, 1'b1);
    send_req(rnmc_pkg::FuncCell, 1'b1);
    send_req(rnmc_pkg::FuncCell, 1'b0);
    repeat (3) send_req(rnmc_pkg::FuncDrain, 1'b0);
    quiesce();

    while (requests_sent < 1600) run_phase();

    quiesce();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rnmc_pkg.sv
sv/rnmc_cell.sv
sv/rnmc_window.sv
sv/raster_neighbor_mark_count.sv
dv/rnmc_checker.sv
dv/testbench.sv
